// ===== design/node_liveness_table_assert.svh =====
// Assertion macros used by the node liveness table engine (nlt_back).
`ifndef NODE_LIVENESS_TABLE_ASSERT_SVH
`define NODE_LIVENESS_TABLE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define NLT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define NLT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define NLT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nlt_pkg.sv =====
// Types and constants of the node liveness table.
package nlt_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

    // Request codes
    localparam logic [2:0] REQ_ADD         = 3'd0;
    localparam logic [2:0] REQ_REMOVE      = 3'd1;
    localparam logic [2:0] REQ_REFRESH     = 3'd2;
    localparam logic [2:0] REQ_REFRESH_ALL = 3'd3;
    localparam logic [2:0] REQ_CHECK       = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_PRESENT   = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] node_id;
        logic [31:0] now_ms;
    } nlt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        expired_valid;
        logic [15:0] expired_id;
        logic [4:0]  node_count;
    } nlt_rsp_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_REFRESH,
        OP_REFRESH_ALL,
        OP_CHECK,
        OP_NOP
    } nlt_op_t;

    typedef struct packed {
        nlt_op_t     op;
        logic [15:0] node_id;
        logic [31:0] now_ms;
    } nlt_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } nlt_state_t;

    typedef struct packed {
        logic pop;
        logic scan;
        logic exec;
    } nlt_back_ctl_t;

endpackage

// ===== design/nlt_front.sv =====
// Front end: accepts requests and decodes them into table commands.
module nlt_front import nlt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nlt_req_t s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output nlt_cmd_t push_cmd
);

    logic     front_valid_reg;
    logic     front_valid_next;
    nlt_cmd_t front_cmd_reg;
    nlt_cmd_t front_cmd_next;
    logic     s_xfer;
    logic     push_xfer;

    assign s_ready   = !front_valid_reg || push_ready;
    assign s_xfer    = s_valid && s_ready;
    assign push_xfer = front_valid_reg && push_ready;

    always_comb begin
        front_cmd_next.node_id = s_data.node_id;
        front_cmd_next.now_ms  = s_data.now_ms;
        unique case (s_data.req_type)
            REQ_ADD:         front_cmd_next.op = OP_ADD;
            REQ_REMOVE:      front_cmd_next.op = OP_REMOVE;
            REQ_REFRESH:     front_cmd_next.op = OP_REFRESH;
            REQ_REFRESH_ALL: front_cmd_next.op = OP_REFRESH_ALL;
            REQ_CHECK:       front_cmd_next.op = OP_CHECK;
            default:         front_cmd_next.op = OP_NOP;
        endcase
    end

    always_comb begin
        front_valid_next = front_valid_reg;
        if (s_xfer) begin
            front_valid_next = 1'b1;
        end else if (push_xfer) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            front_cmd_reg <= front_cmd_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_cmd   = front_cmd_reg;

endmodule

// ===== design/nlt_fifo.sv =====
// Short command queue between the front end and the table engine.
module nlt_fifo import nlt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  nlt_cmd_t push_cmd,
    output logic     q_valid,
    input  logic     q_pop,
    output nlt_cmd_t q_cmd
);

    nlt_cmd_t           store_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QDEPTH);
    assign q_valid    = cnt_reg != '0;
    assign q_cmd      = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/nlt_back.sv =====
// Table engine: entry storage, lookup and timeout scan, update and result register.
`include "node_liveness_table_assert.svh"
module nlt_back import nlt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        q_valid,
    output logic        q_pop,
    input  nlt_cmd_t    q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output nlt_rsp_t    m_data
);

    nlt_state_t         state_reg;
    nlt_state_t         state_next;
    nlt_back_ctl_t      ctl;
    nlt_cmd_t           cmd_reg;
    logic [31:0]        timeout_reg;
    logic [15:0]        ids_reg   [MAX_NODES];
    logic [15:0]        ids_next  [MAX_NODES];
    logic [31:0]        seen_reg  [MAX_NODES];
    logic [31:0]        seen_next [MAX_NODES];
    logic [31:0]        elapsed   [MAX_NODES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [MAX_NODES-1:0] match_reg;
    logic [MAX_NODES-1:0] match_next;
    logic [MAX_NODES-1:0] exp_reg;
    logic [MAX_NODES-1:0] exp_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    nlt_rsp_t           out_data_reg;
    nlt_rsp_t           out_data_next;
    logic               hit;
    logic               full;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   exp_idx;
    logic [IDX_W-1:0]   add_idx;

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: ctl.pop  = q_valid && (!out_valid_reg || m_ready);
            ST_SCAN: ctl.scan = 1'b1;
            ST_EXEC: ctl.exec = 1'b1;
            default: ctl      = '0;
        endcase
    end

    assign q_pop = ctl.pop;

    // Per-entry lookup and elapsed-time compare, one lane per entry
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            elapsed[i]    = cmd_reg.now_ms - seen_reg[i];
            match_next[i] = (CNT_W'(i) < count_reg) && (ids_reg[i] == cmd_reg.node_id);
            exp_next[i]   = (CNT_W'(i) < count_reg) && (elapsed[i] >= timeout_reg);
        end
    end

    // First match and last expired entry
    always_comb begin
        hit_idx = '0;
        exp_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            if (exp_reg[i]) begin
                exp_idx = IDX_W'(i);
            end
        end
    end

    assign hit     = |match_reg;
    assign full    = count_reg == CNT_W'(MAX_NODES);
    assign add_idx = IDX_W'(count_reg);

    // Table update and result
    always_comb begin
        ids_next      = ids_reg;
        seen_next     = seen_reg;
        count_next    = count_reg;
        out_data_next = '0;
        if (ctl.exec) begin
            out_data_next.status = STAT_DONE;
            unique case (cmd_reg.op)
                OP_ADD: begin
                    if (hit) begin
                        out_data_next.status = STAT_PRESENT;
                    end else if (full) begin
                        out_data_next.status = STAT_FULL;
                    end else begin
                        ids_next[add_idx]  = cmd_reg.node_id;
                        seen_next[add_idx] = cmd_reg.now_ms;
                        count_next         = count_reg + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!hit) begin
                        out_data_next.status = STAT_NOT_FOUND;
                    end else begin
                        // close the gap: everything above the hit moves down one
                        for (int i = 0; i < MAX_NODES - 1; i++) begin
                            if (IDX_W'(i) >= hit_idx) begin
                                ids_next[i]  = ids_reg[i + 1];
                                seen_next[i] = seen_reg[i + 1];
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_REFRESH: begin
                    if (!hit) begin
                        out_data_next.status = STAT_NOT_FOUND;
                    end else begin
                        seen_next[hit_idx] = cmd_reg.now_ms;
                    end
                end
                OP_REFRESH_ALL: begin
                    for (int i = 0; i < MAX_NODES; i++) begin
                        seen_next[i] = cmd_reg.now_ms;
                    end
                end
                OP_CHECK: begin
                    if (|exp_reg) begin
                        out_data_next.expired_valid = 1'b1;
                        out_data_next.expired_id    = ids_reg[exp_idx];
                    end
                end
                default: begin
                    out_data_next.status = STAT_DONE;
                end
            endcase
            out_data_next.node_count = 5'(count_next);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.exec) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.pop) begin
            cmd_reg <= q_cmd;
        end
        if (ctl.scan) begin
            match_reg <= match_next;
            exp_reg   <= exp_next;
        end
        if (ctl.exec) begin
            out_data_reg <= out_data_next;
        end
        ids_reg  <= ids_next;
        seen_reg <= seen_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `NLT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_NODES), "entry count above table size")
    `NLT_ASSERT_IMPLY(a_exec_out_free, aclk, aresetn, state_reg == ST_EXEC, !out_valid_reg, "result register busy at update")
    `NLT_ASSERT_NEXT(a_exec_result, aclk, aresetn, state_reg == ST_EXEC, out_valid_reg && state_reg == ST_IDLE, "update gave no result")

endmodule

// ===== design/node_liveness_table.sv =====
// Node liveness table: ordered node IDs with last-seen times and timeout scan.
//
// Request channel (s_valid/s_ready/s_data): one request per transfer, holding
// req_type, node_id and now_ms. Result channel (m_valid/m_ready/m_data): one
// result per request, in request order, holding status, expired_valid,
// expired_id and node_count. cfg_wr_en/cfg_wr_data write timeout_ms.
//
// A request is taken into an input register, decoded and queued (two slots).
// The table engine then takes each request through three steps: pop, a scan
// step in which all entries are compared against the ID and the timeout in
// parallel lanes, and an update step that loads the result register. The
// engine pops a new request only after the update of the last one, and only
// when the result register is free or being taken by the receiver.
//
// When the receiver stalls, the result register holds its result, the engine
// stops at the next request, and the queue and input register keep taking
// requests until they fill. Reset (aresetn low, synchronous) empties the
// table, the queue and the result register and sets timeout_ms to 60000.
module node_liveness_table import nlt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  nlt_req_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output nlt_rsp_t    m_data
);

    logic     push_valid;
    logic     push_ready;
    nlt_cmd_t push_cmd;
    logic     q_valid;
    logic     q_pop;
    nlt_cmd_t q_cmd;

    nlt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    nlt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd)
    );

    nlt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
